[rtl/keypad_autorepeat_scanner_unit_assert.svh]
// ----------------------------------------------------------------------------
// Keypad auto-repeat scanner assertion macros
// Shared property forms for the scanner's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_AUTOREPEAT_SCANNER_UNIT_ASSERT_SVH
`define KEYPAD_AUTOREPEAT_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define KAS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KAS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/kas_pkg.sv]
// ----------------------------------------------------------------------------
// Keypad auto-repeat scanner package
// Sizes, codes, transaction payloads and control/status bundles.
// ----------------------------------------------------------------------------
package kas_pkg;

    localparam int NUM_KEYS   = 8;
    localparam int FIFO_DEPTH = 16;
    localparam int LEVEL_BITS = 8;

    localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int CODE_W = 4;
    localparam int CNT_W  = 4;
    localparam int TIME_W = 32;
    localparam int INTV_W = 31;
    localparam int CFG_IDX_W = 2;

    // transaction modes
    localparam logic [1:0] MODE_SCAN  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTV  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_INTV = 2'd3;

    localparam logic [INTV_W-1:0] RST_FIRST_OFFSET = 31'd14400000;
    localparam logic [INTV_W-1:0] RST_REPEAT_INTV  = 31'd4800000;
    localparam logic [INTV_W-1:0] RST_RELEASE_INTV = 31'd2400000;

    typedef struct packed {
        logic [1:0]        mode;
        logic [7:0]        key_levels;
        logic [TIME_W-1:0] time_now;
    } kas_req_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              any_held;
        logic [CNT_W-1:0]  fifo_count;
    } kas_rsp_t;

    typedef struct packed {
        logic load_item;
        logic scan_step;
        logic finish;
    } kas_cmd_t;

    typedef struct packed {
        logic start_scan;
        logic key_last;
        logic out_busy;
    } kas_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } kas_state_t;

endpackage

[rtl/kas_ctrl.sv]
// ----------------------------------------------------------------------------
// Keypad scanner controller
// Sequences accept, per-key scan steps and result hand-off.
// ----------------------------------------------------------------------------
module kas_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  kas_pkg::kas_sts_t sts,
    output kas_pkg::kas_cmd_t cmd
);
    import kas_pkg::*;

    kas_state_t state_reg;
    kas_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = sts.start_scan ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.key_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // wait for the output register to drain
                if (!sts.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/kas_datapath.sv]
// ----------------------------------------------------------------------------
// Keypad scanner datapath
// Config registers, key state, stamps, code ring and result register.
// ----------------------------------------------------------------------------
module kas_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [kas_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kas_pkg::INTV_W-1:0]     cfg_data,
    input  kas_pkg::kas_req_t              req,
    output kas_pkg::kas_rsp_t              rsp,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  kas_pkg::kas_cmd_t              cmd,
    output kas_pkg::kas_sts_t              sts
);
    import kas_pkg::*;

    // configuration
    logic              scan_enable_reg;
    logic [INTV_W-1:0] first_offset_reg;
    logic [INTV_W-1:0] repeat_intv_reg;
    logic [INTV_W-1:0] release_intv_reg;

    // control state
    logic [NUM_KEYS-1:0] held_reg;
    logic [NUM_KEYS-1:0] held_next;
    logic [PTR_W-1:0]    wp_reg;
    logic [PTR_W-1:0]    wp_next;
    logic [PTR_W-1:0]    rp_reg;
    logic [PTR_W-1:0]    rp_next;
    logic [KEY_W-1:0]    key_idx_reg;
    logic                rsp_valid_reg;

    // payload
    kas_req_t            item_reg;
    kas_rsp_t            rsp_reg;
    logic [TIME_W-1:0]   repeat_stamp [NUM_KEYS];
    logic [TIME_W-1:0]   seen_stamp   [NUM_KEYS];
    logic [CODE_W-1:0]   ring         [FIFO_DEPTH];

    // per-key step
    logic [NUM_KEYS-1:0] level_vec;
    logic                pressed;
    logic                held;
    logic [TIME_W-1:0]   cmp_stamp;
    logic [INTV_W-1:0]   cmp_intv;
    logic [TIME_W-1:0]   diff;
    logic                passed;
    logic                push;
    logic                ring_full;
    logic [PTR_W-1:0]    wp_inc;
    logic [PTR_W-1:0]    rp_inc;
    logic [CODE_W-1:0]   step_code;
    logic                ring_empty;
    logic [CODE_W-1:0]   pop_code;
    logic [PTR_W:0]      count_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enable_reg  <= 1'b1;
            first_offset_reg <= RST_FIRST_OFFSET;
            repeat_intv_reg  <= RST_REPEAT_INTV;
            release_intv_reg <= RST_RELEASE_INTV;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCAN_ENABLE:  scan_enable_reg  <= cfg_data[0];
                CFG_FIRST_OFFSET: first_offset_reg <= cfg_data;
                CFG_REPEAT_INTV:  repeat_intv_reg  <= cfg_data;
                CFG_RELEASE_INTV: release_intv_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign level_vec = NUM_KEYS'(item_reg.key_levels);
    assign pressed   = level_vec[key_idx_reg];
    assign held      = held_reg[key_idx_reg];

    // one wrap-safe compare per key: repeat when pressed, release otherwise
    assign cmp_stamp = pressed ? repeat_stamp[key_idx_reg] : seen_stamp[key_idx_reg];
    assign cmp_intv  = pressed ? repeat_intv_reg : release_intv_reg;
    assign diff      = item_reg.time_now - cmp_stamp;
    assign passed    = !diff[TIME_W-1] && (diff[INTV_W-1:0] >= cmp_intv);

    assign push      = cmd.scan_step && pressed && (!held || passed);
    assign wp_inc    = (wp_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc    = (rp_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign ring_full = (wp_inc == rp_reg);
    assign ring_empty = (wp_reg == rp_reg);
    assign step_code = CODE_W'(key_idx_reg) + 1'b1;
    assign pop_code  = (item_reg.mode == MODE_POP && !ring_empty) ? ring[rp_reg] : '0;

    always_comb
    begin
        held_next = held_reg;
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        if (cmd.scan_step)
        begin
            if (pressed)
            begin
                held_next[key_idx_reg] = 1'b1;
            end
            else if (held && passed)
            begin
                held_next[key_idx_reg] = 1'b0;
            end
            if (push && !ring_full)
            begin
                wp_next = wp_inc;
            end
        end
        if (cmd.finish)
        begin
            case (item_reg.mode)
                MODE_POP:
                begin
                    if (!ring_empty)
                    begin
                        rp_next = rp_inc;
                    end
                end
                MODE_FLUSH: rp_next = wp_reg;
                default: ;
            endcase
        end
    end

    assign count_wide = (wp_next >= rp_next)
                        ? {1'b0, wp_next} - {1'b0, rp_next}
                        : {1'b0, wp_next} + (PTR_W+1)'(FIFO_DEPTH) - {1'b0, rp_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            key_idx_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            if (cmd.load_item)
            begin
                key_idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                key_idx_reg <= key_idx_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= req;
        end
        if (cmd.scan_step)
        begin
            if (pressed)
            begin
                seen_stamp[key_idx_reg] <= item_reg.time_now;
                if (!held)
                begin
                    repeat_stamp[key_idx_reg] <= item_reg.time_now
                                                 + TIME_W'(first_offset_reg);
                end
                else if (passed)
                begin
                    repeat_stamp[key_idx_reg] <= item_reg.time_now;
                end
            end
        end
        if (push && !ring_full)
        begin
            ring[wp_reg] <= step_code;
        end
        if (cmd.finish)
        begin
            rsp_reg.key_code   <= pop_code;
            rsp_reg.any_held   <= |held_reg;
            rsp_reg.fifo_count <= CNT_W'(count_wide);
        end
    end

    assign sts.start_scan = (req.mode == MODE_SCAN) && scan_enable_reg;
    assign sts.key_last   = (key_idx_reg == KEY_W'(NUM_KEYS - 1));
    assign sts.out_busy   = rsp_valid_reg && rsp_stall;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

[rtl/keypad_autorepeat_scanner_unit.sv]
// ----------------------------------------------------------------------------
// Keypad auto-repeat scanner unit
// Key scanner with per-key auto-repeat timing and a ring of key codes.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   kas_req_t  (mode, levels, time)
//   rsp      out        rsp_valid / rsp_stall   kas_rsp_t  (code, held, count)
//   cfg      in         cfg_we                  cfg_index, cfg_data
//
// A scan transaction with scanning enabled is accepted, walks the 8 keys one by
// one through the single compare unit, then posts its result. Pop, flush,
// unused-mode and disabled-scan transactions go straight from accept to posting.
// Reset is asynchronous; config comes up at its reset values and the ring
// empty. No clearing pass. A result held by rsp_stall does not block the
// next accept; only the final posting cycle waits for the output register.
// ----------------------------------------------------------------------------
`include "keypad_autorepeat_scanner_unit_assert.svh"

module keypad_autorepeat_scanner_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [kas_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [kas_pkg::INTV_W-1:0]    cfg_data,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  kas_pkg::kas_req_t             req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output kas_pkg::kas_rsp_t             rsp
);
    import kas_pkg::*;

    kas_cmd_t cmd;
    kas_sts_t sts;

    // controller: accept, walk the keys, post the result
    kas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: timing compare, held flags, code ring, result register
    kas_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // a posted code is always zero or a valid key code
    `KAS_ASSERT_NOW(a_code_range, rsp_valid, rsp.key_code <= CODE_W'(NUM_KEYS), "bad key code")

    // a new result only ever comes out of the posting step
    `KAS_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid), $past(cmd.finish), "stray result")

    // the block is busy the cycle after taking a transaction
    `KAS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "double accept")

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Keypad auto-repeat scanner testbench
// Drives scan, pop, flush and unused-mode transactions into the scanner unit.
// A cycle-free predictor of the key timing and the code ring computes each
// expected result, and the monitor checks results field by field. Register
// settings change between phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import kas_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int GAP_MAX       = 18;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int ITEMS_PER_SET = 150;

    localparam int SIDE_REQ = 0;
    localparam int SIDE_RSP = 1;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [INTV_W-1:0]    cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    kas_req_t             req       = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    kas_rsp_t             rsp;

    keypad_autorepeat_scanner_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: registers, held flags, per-key stamps and the code ring
    // ------------------------------------------------------------------------
    logic                scan_on;
    logic [INTV_W-1:0]   first_ofs;
    logic [INTV_W-1:0]   repeat_span;
    logic [INTV_W-1:0]   release_span;
    logic [NUM_KEYS-1:0] held_keys;
    logic [TIME_W-1:0]   next_repeat_at [NUM_KEYS];
    logic [TIME_W-1:0]   last_pressed_at [NUM_KEYS];
    logic [CODE_W-1:0]   code_ring [FIFO_DEPTH];
    logic [PTR_W-1:0]    ring_wr;
    logic [PTR_W-1:0]    ring_rd;

    kas_req_t pending_req_q [$];   // transactions not yet offered
    kas_rsp_t expected_rsp_q [$];  // predicted results, oldest first

    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_settings = 0;
    int n_popped   = 0;
    int n_dropped  = 0;
    int calm_left [2] = '{0, 0};
    int gap_left   = 0;
    int stall_left = 0;
    int cycle_count = 0;

    logic [TIME_W-1:0] tick;
    logic [7:0]        cur_levels;

    // Wrap-safe "has span passed": the difference is read as signed, so
    // anything at or beyond half the counter range counts as not yet.
    function automatic bit span_elapsed(logic [TIME_W-1:0] now, logic [TIME_W-1:0] since,
                                        logic [INTV_W-1:0] span);
        logic [TIME_W-1:0] d;
        d = now - since;
        return !d[TIME_W-1] && (d >= {1'b0, span});
    endfunction

    // One slot always stays empty; a push into a full ring is lost.
    function automatic void ring_push(logic [CODE_W-1:0] code);
        logic [PTR_W-1:0] nxt;
        nxt = ring_wr + 1'b1;
        if (nxt != ring_rd)
        begin
            code_ring[ring_wr] = code;
            ring_wr = nxt;
        end
        else
            n_dropped++;
    endfunction

    function automatic kas_rsp_t scanner_predict(kas_req_t t);
        kas_rsp_t r;
        r = '0;
        case (t.mode)
            MODE_SCAN:
                if (scan_on)
                begin
                    // keys walk in index order, so push order is low key first
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (t.key_levels[k])
                        begin
                            if (!held_keys[k])
                            begin
                                next_repeat_at[k] = t.time_now + {1'b0, first_ofs};
                                held_keys[k] = 1'b1;
                                ring_push(CODE_W'(k + 1));
                            end
                            else if (span_elapsed(t.time_now, next_repeat_at[k], repeat_span))
                            begin
                                next_repeat_at[k] = t.time_now;
                                ring_push(CODE_W'(k + 1));
                            end
                            last_pressed_at[k] = t.time_now;
                        end
                        else if (held_keys[k] &&
                                 span_elapsed(t.time_now, last_pressed_at[k], release_span))
                            held_keys[k] = 1'b0;
                    end
                end
            MODE_POP:
                if (ring_rd != ring_wr)
                begin
                    r.key_code = code_ring[ring_rd];
                    ring_rd = ring_rd + 1'b1;
                    n_popped++;
                end
            MODE_FLUSH:
                ring_rd = ring_wr;
            default:
                ;
        endcase
        r.any_held   = |held_keys;
        r.fifo_count = CNT_W'(ring_wr - ring_rd);
        return r;
    endfunction

    // Idle draw per transaction; now and then a stretch with no idling at all.
    function automatic int draw_wait(int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left[side] = $urandom_range(10, 40);
            return 0;
        end
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h (result %0d)",
                 $time, what, got, want, n_checked);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued transactions, predicts each one as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp_q.push_back(scanner_predict(req));
                n_accepted++;
                gap_left = draw_wait(SIDE_REQ);
            end
            // a stalled transaction keeps its payload and valid untouched
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (pending_req_q.size() != 0)
                begin
                    req       <= pending_req_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each accepted result against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        kas_rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                    report_mismatch("unexpected result", 32'(rsp), 32'd0);
                else
                begin
                    want = expected_rsp_q.pop_front();
                    n_checked++;
                    if (rsp.key_code !== want.key_code)
                        report_mismatch("key_code", 32'(rsp.key_code), 32'(want.key_code));
                    if (rsp.any_held !== want.any_held)
                        report_mismatch("any_held", 32'(rsp.any_held), 32'(want.any_held));
                    if (rsp.fifo_count !== want.fifo_count)
                        report_mismatch("fifo_count", 32'(rsp.fifo_count),
                                        32'(want.fifo_count));
                end
                stall_left = draw_wait(SIDE_RSP);
            end
            else if (rsp_valid && stall_left > 0)
                stall_left--;
            // stall may also go up ahead of the next result
            rsp_stall <= (stall_left > 0);
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run limit of %0d cycles hit with %0d results outstanding",
                     CYCLE_LIMIT, expected_rsp_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_item(logic [1:0] m, logic [7:0] lv, logic [TIME_W-1:0] t);
        kas_req_t it;
        it.mode       = m;
        it.key_levels = lv;
        it.time_now   = t;
        pending_req_q.push_back(it);
    endfunction

    // Everything offered, accepted and answered, then a settling margin.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [INTV_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_SCAN_ENABLE:  scan_on      = val[0];
            CFG_FIRST_OFFSET: first_ofs    = val;
            CFG_REPEAT_INTV:  repeat_span  = val;
            CFG_RELEASE_INTV: release_span = val;
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_timing(logic [INTV_W-1:0] first, logic [INTV_W-1:0] rep,
                                logic [INTV_W-1:0] rel);
        cfg_write(CFG_FIRST_OFFSET, first);
        cfg_write(CFG_REPEAT_INTV, rep);
        cfg_write(CFG_RELEASE_INTV, rel);
        n_settings++;
    endtask

    // Mostly scans of slowly changing key patterns so keys are held long
    // enough to repeat and release; time steps land on and around the
    // programmed intervals, with the odd half-range jump or backward step.
    task automatic queue_random_run(int n);
        logic [1:0]        m;
        logic [TIME_W-1:0] step_max;
        int                r;
        step_max = (repeat_span > 31'h3FFF_FFFF) ? 32'h3FFF_FFFF
                                                 : {1'b0, repeat_span} / 3 + 2;
        tick = $urandom;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
                m = MODE_SCAN;
            else if (r < 92)
                m = MODE_POP;
            else if (r < 97)
                m = MODE_FLUSH;
            else
                m = MODE_UNUSED;
            if (m == MODE_SCAN)
            begin
                case ($urandom_range(0, 7))
                    0:       cur_levels ^= 8'(1 << $urandom_range(0, 7));
                    1:       cur_levels = 8'($urandom);
                    2:       cur_levels = '0;
                    default: ;
                endcase
                case ($urandom_range(0, 15))
                    0:       tick += {1'b0, repeat_span};
                    1:       tick += {1'b0, release_span};
                    2:       tick += {1'b0, repeat_span} - 1;
                    3:       tick += 32'h8000_0000;
                    4:       tick += 32'($urandom);
                    5:       tick -= $urandom_range(0, 50);
                    default: tick += $urandom_range(0, step_max);
                endcase
                queue_item(m, cur_levels, tick);
            end
            else
                queue_item(m, 8'($urandom), 32'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [TIME_W-1:0] t_rep;
        logic [TIME_W-1:0] t_wrap;

        scan_on      = 1'b1;
        first_ofs    = RST_FIRST_OFFSET;
        repeat_span  = RST_REPEAT_INTV;
        release_span = RST_RELEASE_INTV;
        held_keys    = '0;
        ring_wr      = '0;
        ring_rd      = '0;
        cur_levels   = '0;
        tick         = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at reset register values.
        t_rep  = 32'd100 + {1'b0, RST_FIRST_OFFSET} + {1'b0, RST_REPEAT_INTV};
        t_wrap = 32'hFFFF_FFF0;
        queue_item(MODE_POP, 8'h00, 32'h0);            // pop from an empty ring
        queue_item(MODE_FLUSH, 8'hFF, 32'hFFFF_FFFF);  // flush of an empty ring
        queue_item(MODE_UNUSED, 8'hA5, 32'h1234_5678); // unused mode is a no-op
        queue_item(MODE_SCAN, 8'h00, 32'd0);
        queue_item(MODE_SCAN, 8'hFF, 32'd100);         // all eight keys go down
        queue_item(MODE_SCAN, 8'hFF, 32'd200);         // held, first delay not up
        queue_item(MODE_SCAN, 8'hFF, t_rep - 1);       // one tick short of repeat
        queue_item(MODE_SCAN, 8'hFF, t_rep);           // repeat fills ring, last code lost
        queue_item(MODE_SCAN, 8'hFF, t_rep + {1'b0, RST_REPEAT_INTV}); // full ring drops all
        queue_item(MODE_POP, 8'h00, 32'h0);
        queue_item(MODE_SCAN, 8'h00, t_rep + {1'b0, RST_REPEAT_INTV}
                                     + {1'b0, RST_RELEASE_INTV} - 1); // release too short
        queue_item(MODE_SCAN, 8'h00, t_rep + {1'b0, RST_REPEAT_INTV}
                                     + {1'b0, RST_RELEASE_INTV});     // all keys let go
        queue_item(MODE_POP, 8'hFF, 32'hFFFF_FFFF);
        queue_item(MODE_FLUSH, 8'h00, 32'h0);
        queue_item(MODE_POP, 8'h00, 32'h0);
        queue_item(MODE_SCAN, 8'h81, t_wrap);          // stamp wraps past zero
        queue_item(MODE_SCAN, 8'h81, t_wrap + {1'b0, RST_FIRST_OFFSET}
                                     + {1'b0, RST_REPEAT_INTV});
        queue_item(MODE_SCAN, 8'h81, t_wrap + 32'h8000_0000); // just under half range, still a repeat
        queue_item(MODE_SCAN, 8'h01, t_wrap + 32'hFFFF_0000); // key 7 up, last press long ago
        queue_item(MODE_POP, 8'h00, 32'h0);
        queue_item(MODE_UNUSED, 8'h5A, 32'hAAAA_5555);
        wait_idle();

        // Scanning switched off: scans must leave everything alone.
        cfg_write(CFG_SCAN_ENABLE, {30'h2AAA_AAAA, 1'b0});
        @(negedge clk);
        queue_item(MODE_SCAN, 8'hFF, 32'h0);
        queue_item(MODE_SCAN, 8'h3C, 32'h7FFF_FFFF);
        queue_item(MODE_POP, 8'h00, 32'h0);
        queue_item(MODE_SCAN, 8'h00, 32'hFFFF_FFFF);
        queue_item(MODE_SCAN, 8'hC3, 32'h8000_0000);
        queue_item(MODE_POP, 8'h00, 32'h0);
        wait_idle();
        cfg_write(CFG_SCAN_ENABLE, {30'h1555_5555, 1'b1});

        // Random phases over several timing settings, extremes included.
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: apply_timing(31'd30, 31'd20, 31'd10);
                1: apply_timing(31'd0, 31'd0, 31'd0);   // zero intervals: a held key repeats on any forward time step
                2: apply_timing(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
                3: apply_timing(31'd5, 31'd1, 31'd60);
                4: apply_timing(31'($urandom_range(0, 200)), 31'($urandom_range(1, 100)),
                                31'($urandom_range(0, 100)));
                default: apply_timing(31'($urandom), 31'($urandom), 31'($urandom));
            endcase
            @(negedge clk);
            queue_random_run(ITEMS_PER_SET);
            wait_idle();
        end

        // wait_idle above already covers the drain and the latency margin
        if (expected_rsp_q.size() != 0)
            report_mismatch("results never delivered", 32'(expected_rsp_q.size()), 32'd0);

        $display("Covered %0d transactions and checked %0d results over %0d timing settings.",
                 n_accepted, n_checked, n_settings);
        $display("Ring traffic: %0d codes popped, %0d codes lost to a full ring.",
                 n_popped, n_dropped);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
